>>> rtl/adq_pkg.sv
// shared types and constants for the array deque block
// no dependencies; imported by every module of the block
package adq_pkg;

    localparam int DEPTH  = 8;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int REAR_W = IDX_W + 1;
    localparam int DATA_W = 32;

    // request kinds
    localparam logic [1:0] REQ_INS_REAR  = 2'd0;
    localparam logic [1:0] REQ_INS_FRONT = 2'd1;
    localparam logic [1:0] REQ_DEL_FRONT = 2'd2;
    localparam logic [1:0] REQ_DEL_REAR  = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK            = 2'd0;
    localparam logic [1:0] ST_OVERFLOW      = 2'd1;
    localparam logic [1:0] ST_FRONT_BLOCKED = 2'd2;
    localparam logic [1:0] ST_UNDERFLOW     = 2'd3;

    typedef struct packed {
        logic [1:0]               req_type;
        logic signed [DATA_W-1:0] value;
    } adq_req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] removed_value;
    } adq_rsp_t;

    typedef struct packed {
        logic capture;   // latch the incoming request
        logic exec;      // update indices, access slot memory
        logic load_out;  // fill the result register
    } adq_cmd_t;

endpackage

>>> rtl/adq_ctrl.sv
// sequencing state machine for the array deque block
// depends on adq_pkg
module adq_ctrl
    import adq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output adq_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_LOAD = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: state_next = ST_LOAD;
            ST_LOAD: state_next = ST_OUT;
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = (state_reg == ST_OUT);
    assign cmd.capture  = s_valid && (state_reg == ST_IDLE);
    assign cmd.exec     = (state_reg == ST_EXEC);
    assign cmd.load_out = (state_reg == ST_LOAD);

    a_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("controller state not one-hot");

    a_exec_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> cmd.exec)
        else $error("accepted request not executed");

    a_out_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_valid && !s_ready)
        else $error("result not presented after load");

endmodule

>>> rtl/adq_dpath.sv
// index registers, slot memory and result register of the array deque
// depends on adq_pkg; driven by adq_ctrl commands
module adq_dpath
    import adq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  adq_cmd_t cmd,
    input  adq_req_t s_req,
    output adq_rsp_t m_rsp
);

    localparam logic signed [REAR_W-1:0] REAR_EMPTY = '1;
    localparam logic signed [REAR_W-1:0] REAR_LAST  = REAR_W'(DEPTH - 1);

    logic [DATA_W-1:0] mem [DEPTH];

    adq_req_t                 req_reg;
    logic [IDX_W-1:0]         front_reg;
    logic [IDX_W-1:0]         front_next;
    logic signed [REAR_W-1:0] rear_reg;
    logic signed [REAR_W-1:0] rear_next;
    logic [1:0]               status_reg;
    logic [1:0]               status_next;
    logic                     removed_reg;
    logic                     removed_next;
    logic [DATA_W-1:0]        rdata_reg;
    adq_rsp_t                 out_reg;

    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic                     rd_en;
    logic [IDX_W-1:0]         rd_addr;
    logic signed [REAR_W-1:0] front_ext;
    logic                     empty;
    logic                     last_one;
    logic signed [REAR_W-1:0] rear_inc;

    assign front_ext = $signed({1'b0, front_reg});
    assign empty     = front_ext > rear_reg;
    // a delete takes the only element when both indices meet
    assign last_one  = front_ext == rear_reg;
    assign rear_inc  = rear_reg + REAR_W'(1);

    always_comb begin
        front_next   = front_reg;
        rear_next    = rear_reg;
        status_next  = ST_OK;
        removed_next = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = '0;
        rd_en        = 1'b0;
        rd_addr      = '0;
        case (req_reg.req_type)
            REQ_INS_REAR: begin
                if (rear_reg == REAR_LAST) begin
                    status_next = ST_OVERFLOW;
                end else begin
                    rear_next = rear_inc;
                    wr_en     = 1'b1;
                    wr_addr   = rear_inc[IDX_W-1:0];
                end
            end
            REQ_INS_FRONT: begin
                if (front_reg == '0 && rear_reg == REAR_EMPTY) begin
                    rear_next = '0;
                    wr_en     = 1'b1;
                    wr_addr   = '0;
                end else if (front_reg != '0) begin
                    front_next = front_reg - IDX_W'(1);
                    wr_en      = 1'b1;
                    wr_addr    = front_reg - IDX_W'(1);
                end else begin
                    status_next = ST_FRONT_BLOCKED;
                end
            end
            REQ_DEL_FRONT: begin
                if (empty) begin
                    status_next = ST_UNDERFLOW;
                end else begin
                    removed_next = 1'b1;
                    rd_en        = 1'b1;
                    rd_addr      = front_reg;
                    if (last_one) begin
                        front_next = '0;
                        rear_next  = REAR_EMPTY;
                    end else begin
                        front_next = front_reg + IDX_W'(1);
                    end
                end
            end
            REQ_DEL_REAR: begin
                if (empty) begin
                    status_next = ST_UNDERFLOW;
                end else begin
                    removed_next = 1'b1;
                    rd_en        = 1'b1;
                    rd_addr      = rear_reg[IDX_W-1:0];
                    if (last_one) begin
                        front_next = '0;
                        rear_next  = REAR_EMPTY;
                    end else begin
                        rear_next = rear_reg - REAR_W'(1);
                    end
                end
            end
            default: status_next = ST_OK;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            rear_reg  <= REAR_EMPTY;
        end else if (cmd.exec) begin
            front_reg <= front_next;
            rear_reg  <= rear_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg <= s_req;
        end
        if (cmd.exec) begin
            status_reg  <= status_next;
            removed_reg <= removed_next;
        end
        if (cmd.load_out) begin
            out_reg.status        <= status_reg;
            out_reg.removed_value <= removed_reg ? $signed(rdata_reg) : '0;
        end
    end

    // slot memory: one write or one registered read per request
    always_ff @(posedge aclk) begin
        if (cmd.exec && wr_en) begin
            mem[wr_addr] <= req_reg.value;
        end
        if (cmd.exec && rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign m_rsp = out_reg;

    a_empty_is_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> (front_reg == '0 && rear_reg == REAR_EMPTY))
        else $error("empty queue with indices not at reset values");

    a_rear_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rear_reg >= REAR_EMPTY)
        else $error("rear index below empty marker");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> (out_reg.status == ST_OK || out_reg.removed_value == '0))
        else $error("failed request returned nonzero value");

endmodule

>>> rtl/array_deque_unit.sv
// top level of the array deque block: controller plus datapath
// depends on adq_pkg, adq_ctrl, adq_dpath
//
// Double-ended queue over a fixed, non-wrapping array of DEPTH 32-bit slots.
// Each request (insert rear, insert front, delete front, delete rear) gives
// exactly one result with a status code and, for a successful delete, the
// removed element. One request is in flight at a time: a request is taken
// in the idle state, the execute state updates the indices and accesses the
// single-port slot memory, the load state fills the result register from the
// registered memory read, and the result is then shown until taken. The
// next request is accepted the cycle after the result is taken.
module array_deque_unit
    import adq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  adq_req_t s_req,
    output logic     m_valid,
    input  logic     m_ready,
    output adq_rsp_t m_rsp
);

    adq_cmd_t cmd;

    adq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    adq_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_req   (s_req),
        .m_rsp   (m_rsp)
    );

endmodule

>>> verif/tb_array_deque_unit.sv
`timescale 1ns / 1ps
// testbench for array_deque_unit: directed and random deque requests, each
// result checked against a behavioral mirror of the queue kept in the bench
// depends on adq_pkg and the array_deque_unit rtl
module tb_array_deque_unit;
    import adq_pkg::*;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    adq_req_t s_req;
    logic     m_valid;
    logic     m_ready;
    adq_rsp_t m_rsp;

    // mirror of the queue contents and indices
    logic [DATA_W-1:0] shadow_slots [DEPTH];
    int front_idx;
    int rear_idx;

    adq_rsp_t pending_rsp_q [$];
    adq_rsp_t want_rsp;
    int       err_cnt;
    int       rsp_cnt;
    int       kind_cnt [4];
    int       status_cnt [4];
    bit       send_idle_on;
    bit       recv_idle_on;
    int       stall_left;

    array_deque_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rsp   (m_rsp)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // applies one request to the mirror and returns the result it must give
    function automatic adq_rsp_t deque_apply(input adq_req_t r);
        adq_rsp_t rsp;
        rsp.status        = ST_OK;
        rsp.removed_value = '0;
        case (r.req_type)
            REQ_INS_REAR: begin
                if (rear_idx >= DEPTH - 1) begin
                    rsp.status = ST_OVERFLOW;
                end else begin
                    rear_idx++;
                    shadow_slots[rear_idx] = r.value;
                end
            end
            REQ_INS_FRONT: begin
                if (front_idx == 0 && rear_idx == -1) begin
                    rear_idx        = 0;
                    shadow_slots[0] = r.value;
                end else if (front_idx > 0) begin
                    front_idx--;
                    shadow_slots[front_idx] = r.value;
                end else begin
                    rsp.status = ST_FRONT_BLOCKED;
                end
            end
            REQ_DEL_FRONT: begin
                if (front_idx > rear_idx) begin
                    rsp.status = ST_UNDERFLOW;
                end else begin
                    rsp.removed_value = shadow_slots[front_idx];
                    front_idx++;
                end
            end
            default: begin
                if (front_idx > rear_idx) begin
                    rsp.status = ST_UNDERFLOW;
                end else begin
                    rsp.removed_value = shadow_slots[rear_idx];
                    rear_idx--;
                end
            end
        endcase
        // an emptied queue goes back to its reset indices
        if (front_idx > rear_idx) begin
            front_idx = 0;
            rear_idx  = -1;
        end
        return rsp;
    endfunction

    task automatic send_req(input logic [1:0] kind, input logic [DATA_W-1:0] val);
        adq_req_t r;
        r.req_type = kind;
        r.value    = val;
        if (send_idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_req   <= r;
        do @(posedge aclk); while (!s_ready);
        pending_rsp_q.push_back(deque_apply(r));
        kind_cnt[kind]++;
        @(negedge aclk);
    endtask

    // hold off the sender until every outstanding result is back
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_rsp_q.size() != 0);
    endtask

    task automatic random_walk(input int n, input int w_ir, input int w_if,
                               input int w_df, input int w_dr);
        int                pick;
        logic [1:0]        kind;
        logic [DATA_W-1:0] val;
        repeat (n) begin
            pick = $urandom_range(0, w_ir + w_if + w_df + w_dr - 1);
            if (pick < w_ir) kind = REQ_INS_REAR;
            else if (pick < w_ir + w_if) kind = REQ_INS_FRONT;
            else if (pick < w_ir + w_if + w_df) kind = REQ_DEL_FRONT;
            else kind = REQ_DEL_REAR;
            case ($urandom_range(0, 15))
                0: val = 32'h8000_0000;
                1: val = 32'h7FFF_FFFF;
                2: val = '1;
                3: val = '0;
                default: val = $urandom;
            endcase
            send_req(kind, val);
        end
    endtask

    task automatic test_directed();
        // deletes on an empty queue
        send_req(REQ_DEL_FRONT, 32'h1111_1111);
        send_req(REQ_DEL_REAR,  32'h2222_2222);
        // front insert into an empty queue lands in slot zero
        send_req(REQ_INS_FRONT, 32'h7FFF_FFFF);
        send_req(REQ_INS_FRONT, 32'h0000_0001);
        send_req(REQ_DEL_REAR,  32'h0);
        // emptied from the front end
        send_req(REQ_INS_REAR,  32'h0000_0005);
        send_req(REQ_DEL_FRONT, 32'h0);
        // fill to the top, then overflow and a blocked front insert
        send_req(REQ_INS_REAR,  32'h8000_0000);
        send_req(REQ_INS_REAR,  32'hFFFF_FFFF);
        send_req(REQ_INS_REAR,  32'h0000_0000);
        send_req(REQ_INS_REAR,  32'h7FFF_FFFF);
        send_req(REQ_INS_REAR,  32'h5555_5555);
        send_req(REQ_INS_REAR,  32'hAAAA_AAAA);
        send_req(REQ_INS_REAR,  32'h0000_0001);
        send_req(REQ_INS_REAR,  32'h1234_5678);
        send_req(REQ_INS_REAR,  32'h0BAD_F00D);
        send_req(REQ_INS_FRONT, 32'h0BAD_F00D);
        // free slots below the front and reuse them
        send_req(REQ_DEL_FRONT, 32'h0);
        send_req(REQ_DEL_FRONT, 32'h0);
        send_req(REQ_INS_FRONT, 32'hDEAD_BEEF);
        send_req(REQ_INS_FRONT, 32'h8000_0001);
        send_req(REQ_INS_FRONT, 32'h7FFF_FFFE);
    endtask

    task automatic test_fill_drain();
        repeat (20) begin
            random_walk($urandom_range(6, 14), 8, 1, 1, 1);
            random_walk($urandom_range(6, 14), 1, 1, 4, 4);
        end
    endtask

    task automatic test_front_reuse();
        repeat (15) begin
            random_walk(6, 6, 0, 0, 0);
            random_walk(4, 0, 0, 6, 1);
            random_walk(6, 0, 6, 1, 0);
        end
    endtask

    task automatic test_random_mix();
        random_walk(200, 1, 1, 1, 1);
        wait_drained();
        random_walk(200, 1, 1, 1, 1);
    endtask

    task automatic test_back_to_back();
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        random_walk(180, 3, 2, 2, 2);
    endtask

    // result side: random stall bursts on m_ready
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (recv_idle_on && aresetn && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 12);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_rsp_q.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected result, expected none, actual status %0d value %0d",
                         $time, m_rsp.status, m_rsp.removed_value);
            end else begin
                want_rsp = pending_rsp_q.pop_front();
                rsp_cnt++;
                status_cnt[want_rsp.status]++;
                if (m_rsp.status !== want_rsp.status) begin
                    err_cnt++;
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want_rsp.status, m_rsp.status);
                end
                if (m_rsp.removed_value !== want_rsp.removed_value) begin
                    err_cnt++;
                    $display("%0t: removed_value mismatch, expected %0d, actual %0d",
                             $time, want_rsp.removed_value, m_rsp.removed_value);
                end
            end
        end
    end

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_req        = '0;
        m_ready      = 1'b0;
        err_cnt      = 0;
        rsp_cnt      = 0;
        stall_left   = 0;
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        front_idx    = 0;
        rear_idx     = -1;
        foreach (kind_cnt[i]) kind_cnt[i] = 0;
        foreach (status_cnt[i]) status_cnt[i] = 0;

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_fill_drain();
        test_front_reuse();
        test_random_mix();
        test_back_to_back();

        wait_drained();
        repeat (10) @(negedge aclk);

        $display("requests: %0d ins rear, %0d ins front, %0d del front, %0d del rear",
                 kind_cnt[REQ_INS_REAR], kind_cnt[REQ_INS_FRONT],
                 kind_cnt[REQ_DEL_FRONT], kind_cnt[REQ_DEL_REAR]);
        $display("results checked: %0d (ok %0d, overflow %0d, blocked %0d, underflow %0d)",
                 rsp_cnt, status_cnt[ST_OK], status_cnt[ST_OVERFLOW],
                 status_cnt[ST_FRONT_BLOCKED], status_cnt[ST_UNDERFLOW]);
        if (err_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout: deque stopped responding");
        $display("== FAIL ==");
        $finish;
    end

endmodule
